// ===== sv/bfa_pkg.sv =====
`default_nettype none
package bfa_pkg;

  localparam int FRAME_BITS_DEF  = 16;
  localparam int ORDER_COUNT_DEF = 11;

  localparam int PAGE_COUNT_W  = 16;
  localparam int BLOCK_ORDER_W = 4;
  localparam int STATUS_W      = 3;
  localparam int AVAIL_PAGES_W = 17;
  localparam int CFG_IDX_W     = 1;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_ADD   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOMEM   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADREQ  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DBLFREE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_FIRST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_END   = 1'd1;

  localparam logic [AVAIL_PAGES_W-1:0] AVAIL_PAGES_MAX = 17'h1FFFF;

endpackage
`default_nettype wire

// ===== sv/bfa_if.sv =====
`default_nettype none
interface bfa_req_if
  import bfa_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic [PAGE_COUNT_W-1:0]  page_count;
  logic [BLOCK_ORDER_W-1:0] block_order;
  logic [FRAME_BITS-1:0]    frame_number;
  logic [FRAME_BITS:0]      end_frame;

  modport source (output valid, op, page_count, block_order, frame_number, end_frame,
                  input ready);
  modport sink (input valid, op, page_count, block_order, frame_number, end_frame,
                output ready);
endinterface

interface bfa_rsp_if
  import bfa_pkg::*;
#(
  parameter int FRAME_BITS  = FRAME_BITS_DEF,
  parameter int ORDER_COUNT = ORDER_COUNT_DEF
);
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [FRAME_BITS-1:0]    granted_frame;
  logic [ORDER_COUNT-1:0]   granted_pages;
  logic [AVAIL_PAGES_W-1:0] avail_pages;

  modport source (output valid, status, granted_frame, granted_pages, avail_pages,
                  input ready);
  modport sink (input valid, status, granted_frame, granted_pages, avail_pages,
                output ready);
endinterface
`default_nettype wire

// ===== sv/buddy_frame_allocator.sv =====
// Buddy allocator over the page frames of one zone. Requests arrive on req and each
// one answers with a single transfer on rsp. After reset a clearing pass sweeps the
// frame table, one frame a cycle, before the first request is taken; configuration
// writes are taken throughout. The block works on one request at a time through a
// small sequencer around the frame table, which has one read and one write port per
// field group; every table read is registered. A successful allocate unlinks a free
// block and splits it once per order above the request, and a rejected one ends after
// its checks; a free runs its checks, a double-free search over the orders from the
// block's order up, a merge per level, and the final insert and result, with an unlink
// first when the inserted frame is still on a list; an add range repeats the merge
// for every aligned block it carves. A finished result waits in an output register
// while the next request is taken; the sequencer stalls only when the previous
// result is still held there.
`default_nettype none
module buddy_frame_allocator
  import bfa_pkg::*;
#(
  parameter int FRAME_BITS  = FRAME_BITS_DEF,
  parameter int ORDER_COUNT = ORDER_COUNT_DEF
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_we_i,
  input  wire [CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [FRAME_BITS:0]     cfg_data_i,
  bfa_req_if.sink                req,
  bfa_rsp_if.source              rsp
);

  localparam int FB = FRAME_BITS;
  localparam int OC = ORDER_COUNT;
  localparam int OB = (OC > 1) ? $clog2(OC) : 1;
  localparam int AW = ((FB > OC) ? FB : OC) + 2;
  localparam int TW = FB + 5;
  localparam int CW = (TW > AVAIL_PAGES_W) ? TW : AVAIL_PAGES_W;
  localparam int FRAME_COUNT = 1 << FB;
  localparam logic [FB:0] FULL_END = {1'b1, {FB{1'b0}}};
  localparam logic [PAGE_COUNT_W:0] MAX_CNT = (PAGE_COUNT_W + 1)'(1 << (OC - 1));

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_A0   = 5'd2;
  localparam logic [4:0] S_A1   = 5'd3;
  localparam logic [4:0] S_F0   = 5'd4;
  localparam logic [4:0] S_E0   = 5'd5;
  localparam logic [4:0] S_E1   = 5'd6;
  localparam logic [4:0] S_M0   = 5'd7;
  localparam logic [4:0] S_M1   = 5'd8;
  localparam logic [4:0] S_M2   = 5'd9;
  localparam logic [4:0] S_D0   = 5'd10;
  localparam logic [4:0] S_D1   = 5'd11;
  localparam logic [4:0] S_D2   = 5'd12;
  localparam logic [4:0] S_U0   = 5'd13;
  localparam logic [4:0] S_U1   = 5'd14;
  localparam logic [4:0] S_I0   = 5'd15;
  localparam logic [4:0] S_I1   = 5'd16;
  localparam logic [4:0] S_I2   = 5'd17;
  localparam logic [4:0] S_I3   = 5'd18;
  localparam logic [4:0] S_DONE = 5'd19;

  function automatic logic [AW-1:0] pw(input logic [OB-1:0] o);
    pw = AW'(1) << o;
  endfunction

  // frame table: mark/order, prev link, next link; top bit is the flag
  logic [OB:0] mark_mem [FRAME_COUNT];
  logic [FB:0] prev_mem [FRAME_COUNT];
  logic [FB:0] next_mem [FRAME_COUNT];

  logic          mk_we, pv_we, nx_we;
  logic [FB-1:0] mk_wa, pv_wa, nx_wa, mk_ra, ln_ra;
  logic [OB:0]   mk_wd, mk_rd_q;
  logic [FB:0]   pv_wd, nx_wd, pv_rd_q, nx_rd_q;

  logic [4:0]    st_q, st_d, u_ret_q, u_ret_d, i_ret_q, i_ret_d, m_ret_q, m_ret_d;
  logic [FB-1:0] clr_q, clr_d;
  logic [FB-1:0] zf_q, zf_d;
  logic [FB:0]   ze_q, ze_d;
  logic [FB-1:0] head_q [OC];
  logic [FB-1:0] head_d [OC];
  logic [OC-1:0] head_ok_q, head_ok_d;
  logic [TW-1:0] tot_q, tot_d;

  logic [PAGE_COUNT_W-1:0]  cnt_q, cnt_d;
  logic [BLOCK_ORDER_W-1:0] bord_q, bord_d;
  logic [FB-1:0]            fr_q, fr_d;
  logic [FB:0]              ef_q, ef_d;

  logic [OB-1:0] k_q, k_d, a_o_q, a_o_d, e_o_q, e_o_d, m_o_q, m_o_d;
  logic [OB-1:0] i_o_q, i_o_d, d_o_q, d_o_d;
  logic [FB-1:0] a_f_q, a_f_d, m_f_q, m_f_d, u_f_q, u_f_d, i_f_q, i_f_d, i_old_q, i_old_d;
  logic [FB:0]   s_q, s_d, e_q, e_d;

  logic [STATUS_W-1:0]      sts_q, sts_d, o_sts_q, o_sts_d;
  logic [FB-1:0]            gf_q, gf_d, o_gf_q, o_gf_d;
  logic [OC-1:0]            gp_q, gp_d, o_gp_q, o_gp_d;
  logic [AVAIL_PAGES_W-1:0] o_ap_q, o_ap_d;
  logic                     ov_q, ov_d;

  logic [FB:0]   ze_eff;
  logic [AW-1:0] zf_w, ze_w, h_w, b_w, fr_w, s_w, rem_w;
  logic [CW-1:0] tot_ext;
  logic          b_ok, fr_fits, hit, fnd, bad_cnt;
  logic [OB-1:0] kk, fo, osz, oal, u_ord;

  assign ze_eff = (ze_q > FULL_END) ? FULL_END : ze_q;
  assign zf_w   = AW'(zf_q);
  assign ze_w   = AW'(ze_eff);
  assign fr_w   = AW'(fr_q);
  assign h_w    = fr_w & ~(pw(e_o_q) - AW'(1));
  assign b_w    = AW'(m_f_q) ^ pw(m_o_q);
  assign s_w    = AW'(s_q);
  assign rem_w  = AW'(e_q - s_q);
  assign b_ok   = (b_w >= zf_w) && (b_w < ze_w) && ((b_w & (pw(m_o_q) - AW'(1))) == '0)
                  && (b_w + pw(m_o_q) <= ze_w);
  assign fr_fits = ((fr_w & (pw(OB'(bord_q)) - AW'(1))) == '0) && (fr_w >= zf_w)
                   && (fr_w + pw(OB'(bord_q)) <= ze_w);
  assign hit    = mk_rd_q[OB] && ((e_o_q == OB'(bord_q)) ||
                  ((h_w >= zf_w) && (h_w < ze_w) && (mk_rd_q[OB-1:0] == e_o_q)));
  assign u_ord  = mk_rd_q[OB-1:0];
  assign tot_ext = CW'(tot_q);
  assign bad_cnt = (cnt_q == '0) || ({1'b0, cnt_q} > MAX_CNT);

  always_comb begin
    kk = '0;
    for (int j = OC - 1; j >= 0; j--) begin
      if ({1'b0, cnt_q} <= ((PAGE_COUNT_W + 1)'(1) << j)) kk = OB'(j);
    end
    fnd = 1'b0;
    fo  = '0;
    for (int j = OC - 1; j >= 0; j--) begin
      if (OB'(j) >= kk && head_ok_q[j]) begin
        fnd = 1'b1;
        fo  = OB'(j);
      end
    end
    osz = '0;
    oal = '0;
    for (int j = 1; j < OC; j++) begin
      if (pw(OB'(j)) <= rem_w) osz = OB'(j);
      if ((s_w & (pw(OB'(j)) - AW'(1))) == '0) oal = OB'(j);
    end
  end

  assign req.ready = (st_q == S_IDLE);
  assign rsp.valid = ov_q;
  assign rsp.status = o_sts_q;
  assign rsp.granted_frame = o_gf_q;
  assign rsp.granted_pages = o_gp_q;
  assign rsp.avail_pages = o_ap_q;

  always_comb begin
    st_d = st_q; u_ret_d = u_ret_q; i_ret_d = i_ret_q; m_ret_d = m_ret_q;
    clr_d = clr_q; zf_d = zf_q; ze_d = ze_q;
    head_d = head_q; head_ok_d = head_ok_q; tot_d = tot_q;
    cnt_d = cnt_q; bord_d = bord_q; fr_d = fr_q; ef_d = ef_q;
    k_d = k_q; a_o_d = a_o_q; e_o_d = e_o_q; m_o_d = m_o_q; i_o_d = i_o_q; d_o_d = d_o_q;
    a_f_d = a_f_q; m_f_d = m_f_q; u_f_d = u_f_q; i_f_d = i_f_q; i_old_d = i_old_q;
    s_d = s_q; e_d = e_q;
    sts_d = sts_q; gf_d = gf_q; gp_d = gp_q;
    o_sts_d = o_sts_q; o_gf_d = o_gf_q; o_gp_d = o_gp_q; o_ap_d = o_ap_q; ov_d = ov_q;
    mk_we = 1'b0; mk_wa = u_f_q; mk_wd = '0;
    pv_we = 1'b0; pv_wa = i_f_q; pv_wd = '0;
    nx_we = 1'b0; nx_wa = i_f_q; nx_wd = '0;
    mk_ra = u_f_q; ln_ra = u_f_q;

    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_ZONE_FIRST) zf_d = cfg_data_i[FB-1:0];
      if (cfg_idx_i == CFG_ZONE_END) ze_d = cfg_data_i;
    end
    if (ov_q && rsp.ready) ov_d = 1'b0;

    case (st_q)
      S_CLR: begin
        mk_we = 1'b1;
        mk_wa = clr_q;
        clr_d = clr_q + FB'(1);
        if (clr_q == '1) st_d = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) begin
          cnt_d = req.page_count; bord_d = req.block_order;
          fr_d = req.frame_number; ef_d = req.end_frame;
          sts_d = ST_OK; gf_d = '0; gp_d = '0;
          case (req.op)
            OP_ALLOC: st_d = S_A0;
            OP_FREE:  st_d = S_F0;
            OP_ADD:   st_d = S_D0;
            default: begin
              sts_d = ST_BADREQ;
              st_d  = S_DONE;
            end
          endcase
        end
      end
      S_A0: begin
        if (bad_cnt) begin
          sts_d = ST_BADREQ; st_d = S_DONE;
        end else if (!fnd) begin
          sts_d = ST_NOMEM; st_d = S_DONE;
        end else begin
          k_d = kk; a_o_d = fo; a_f_d = head_q[fo]; u_f_d = head_q[fo];
          u_ret_d = S_A1; st_d = S_U0;
        end
      end
      S_A1: begin
        if (a_o_q > k_q) begin
          a_o_d = a_o_q - OB'(1);
          i_o_d = a_o_q - OB'(1);
          i_f_d = a_f_q + FB'(pw(a_o_q - OB'(1)));
          i_ret_d = S_A1; st_d = S_I0;
        end else begin
          mk_we = 1'b1; mk_wa = a_f_q; mk_wd = {1'b0, k_q};
          gf_d = a_f_q; gp_d = OC'(pw(k_q)); st_d = S_DONE;
        end
      end
      S_F0: begin
        if ({1'b0, bord_q} >= (BLOCK_ORDER_W + 1)'(OC)) begin
          sts_d = ST_BADREQ; st_d = S_DONE;
        end else if (!fr_fits) begin
          sts_d = ST_INVALID; st_d = S_DONE;
        end else begin
          e_o_d = OB'(bord_q); st_d = S_E0;
        end
      end
      S_E0: begin
        mk_ra = FB'(h_w);
        st_d = S_E1;
      end
      S_E1: begin
        if (hit) begin
          sts_d = ST_DBLFREE; st_d = S_DONE;
        end else if (e_o_q == OB'(OC - 1)) begin
          m_f_d = fr_q; m_o_d = OB'(bord_q); m_ret_d = S_DONE; st_d = S_M0;
        end else begin
          e_o_d = e_o_q + OB'(1); st_d = S_E0;
        end
      end
      S_M0: begin
        mk_ra = FB'(b_w);
        if ((m_o_q != OB'(OC - 1)) && b_ok) begin
          st_d = S_M1;
        end else begin
          i_f_d = m_f_q; i_o_d = m_o_q; i_ret_d = m_ret_q; st_d = S_I0;
        end
      end
      S_M1: begin
        if (mk_rd_q[OB] && (mk_rd_q[OB-1:0] == m_o_q)) begin
          u_f_d = FB'(b_w); u_ret_d = S_M2; st_d = S_U0;
        end else begin
          i_f_d = m_f_q; i_o_d = m_o_q; i_ret_d = m_ret_q; st_d = S_I0;
        end
      end
      S_M2: begin
        m_f_d = m_f_q & ~FB'(pw(m_o_q));
        m_o_d = m_o_q + OB'(1);
        st_d = S_M0;
      end
      S_D0: begin
        if ({1'b0, fr_q} < ef_q) begin
          s_d = (fr_q == '0) ? (FB + 1)'(1) : {1'b0, fr_q};
          if (s_d < {1'b0, zf_q}) s_d = {1'b0, zf_q};
          e_d = (ef_q > ze_eff) ? ze_eff : ef_q;
          st_d = S_D1;
        end else begin
          st_d = S_DONE;
        end
      end
      S_D1: begin
        if (s_q < e_q) begin
          m_f_d = s_q[FB-1:0];
          m_o_d = (osz < oal) ? osz : oal;
          d_o_d = (osz < oal) ? osz : oal;
          m_ret_d = S_D2; st_d = S_M0;
        end else begin
          st_d = S_DONE;
        end
      end
      S_D2: begin
        s_d = s_q + (FB + 1)'(pw(d_o_q));
        st_d = S_D1;
      end
      S_U0: begin
        mk_ra = u_f_q; ln_ra = u_f_q;
        st_d = S_U1;
      end
      S_U1: begin
        if (pv_rd_q[FB]) begin
          nx_we = 1'b1; nx_wa = pv_rd_q[FB-1:0]; nx_wd = nx_rd_q;
        end else begin
          head_d[u_ord] = nx_rd_q[FB-1:0];
          head_ok_d[u_ord] = nx_rd_q[FB];
        end
        if (nx_rd_q[FB]) begin
          pv_we = 1'b1; pv_wa = nx_rd_q[FB-1:0]; pv_wd = pv_rd_q;
        end
        tot_d = tot_q - TW'(pw(u_ord));
        mk_we = 1'b1; mk_wa = u_f_q; mk_wd = {1'b0, u_ord};
        st_d = u_ret_q;
      end
      S_I0: begin
        mk_ra = i_f_q;
        st_d = S_I1;
      end
      S_I1: begin
        if (mk_rd_q[OB]) begin
          u_f_d = i_f_q; u_ret_d = S_I2; st_d = S_U0;
        end else begin
          st_d = S_I2;
        end
      end
      S_I2: begin
        mk_we = 1'b1; mk_wa = i_f_q; mk_wd = {1'b1, i_o_q};
        pv_we = 1'b1; pv_wa = i_f_q; pv_wd = '0;
        nx_we = 1'b1; nx_wa = i_f_q; nx_wd = {head_ok_q[i_o_q], head_q[i_o_q]};
        i_old_d = head_q[i_o_q];
        head_d[i_o_q] = i_f_q;
        head_ok_d[i_o_q] = 1'b1;
        tot_d = tot_q + TW'(pw(i_o_q));
        st_d = head_ok_q[i_o_q] ? S_I3 : i_ret_q;
      end
      S_I3: begin
        pv_we = 1'b1; pv_wa = i_old_q; pv_wd = {1'b1, i_f_q};
        st_d = i_ret_q;
      end
      S_DONE: begin
        if (!ov_q || rsp.ready) begin
          ov_d = 1'b1;
          o_sts_d = sts_q; o_gf_d = gf_q; o_gp_d = gp_q;
          o_ap_d = (tot_ext > CW'(AVAIL_PAGES_MAX)) ? AVAIL_PAGES_MAX
                                                    : AVAIL_PAGES_W'(tot_q);
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mk_we) mark_mem[mk_wa] <= mk_wd;
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    mk_rd_q <= mark_mem[mk_ra];
    pv_rd_q <= prev_mem[ln_ra];
    nx_rd_q <= next_mem[ln_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR;
      clr_q <= '0;
      zf_q <= '0;
      ze_q <= FULL_END;
      head_ok_q <= '0;
      tot_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      clr_q <= clr_d;
      zf_q <= zf_d;
      ze_q <= ze_d;
      head_ok_q <= head_ok_d;
      tot_q <= tot_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_ret_q <= u_ret_d; i_ret_q <= i_ret_d; m_ret_q <= m_ret_d;
    head_q <= head_d;
    cnt_q <= cnt_d; bord_q <= bord_d; fr_q <= fr_d; ef_q <= ef_d;
    k_q <= k_d; a_o_q <= a_o_d; e_o_q <= e_o_d; m_o_q <= m_o_d; i_o_q <= i_o_d;
    d_o_q <= d_o_d;
    a_f_q <= a_f_d; m_f_q <= m_f_d; u_f_q <= u_f_d; i_f_q <= i_f_d; i_old_q <= i_old_d;
    s_q <= s_d; e_q <= e_d;
    sts_q <= sts_d; gf_q <= gf_d; gp_q <= gp_d;
    o_sts_q <= o_sts_d; o_gf_q <= o_gf_d; o_gp_q <= o_gp_d; o_ap_q <= o_ap_d;
  end

endmodule
`default_nettype wire

// ===== sv/bfa_checker.sv =====
`default_nettype none
module bfa_checker
  import bfa_pkg::*;
#(
  parameter int FRAME_BITS  = FRAME_BITS_DEF,
  parameter int ORDER_COUNT = ORDER_COUNT_DEF
) (
  input wire                    clk_i,
  input wire                    rst_ni,
  input wire                    in_valid_i,
  input wire                    in_ready_i,
  input wire                    out_valid_i,
  input wire                    out_ready_i,
  input wire [STATUS_W-1:0]     status_i,
  input wire [FRAME_BITS-1:0]   granted_frame_i,
  input wire [ORDER_COUNT-1:0]  granted_pages_i
);

  // held result while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(granted_frame_i) && $stable(granted_pages_i))
    else $error("result changed while stalled");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_OK |-> granted_pages_i == '0 && granted_frame_i == '0)
    else $error("grant on failed request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && granted_pages_i != '0 |-> $onehot(granted_pages_i) && status_i == ST_OK)
    else $error("grant size not a power of two");

endmodule

bind buddy_frame_allocator bfa_checker #(
  .FRAME_BITS(FRAME_BITS),
  .ORDER_COUNT(ORDER_COUNT)
) u_bfa_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(req.valid),
  .in_ready_i(req.ready),
  .out_valid_i(rsp.valid),
  .out_ready_i(rsp.ready),
  .status_i(rsp.status),
  .granted_frame_i(rsp.granted_frame),
  .granted_pages_i(rsp.granted_pages)
);
`default_nettype wire

// ===== tb/sv/buddy_frame_allocator_tb.sv =====
`default_nettype none
module buddy_frame_allocator_tb;
  import bfa_pkg::*;

  localparam int NFRAMES = 65536;
  localparam int NORDERS = ORDER_COUNT_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] cnt;
    logic [3:0]  bord;
    logic [15:0] fr;
    logic [16:0] ef;
  } alloc_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] gframe;
    logic [10:0] gpages;
    logic [16:0] apages;
  } alloc_rsp_t;

  typedef struct {
    logic [15:0] fr;
    logic [3:0]  ord;
  } block_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [16:0] cfg_data;

  bfa_req_if req_if();
  bfa_rsp_if rsp_if();

  buddy_frame_allocator dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req        (req_if.sink),
    .rsp        (rsp_if.source)
  );

  // shadow of the frame table and free lists
  bit          fr_mark [NFRAMES];
  bit [3:0]    fr_ord  [NFRAMES];
  bit          fr_pok  [NFRAMES];
  bit          fr_nok  [NFRAMES];
  bit [15:0]   fr_prev [NFRAMES];
  bit [15:0]   fr_next [NFRAMES];
  bit [15:0]   lhead   [NORDERS];
  bit          lhead_ok[NORDERS];
  int unsigned lcount  [NORDERS];
  int unsigned zfirst;
  int unsigned zend_reg;

  alloc_req_t pending_reqs[$];
  alloc_rsp_t expected_rsps[$];
  block_t     live_blocks[$];
  block_t     freed_blocks[$];
  alloc_req_t nxt;

  int unsigned errors;
  int unsigned rsp_checked;
  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned stall_left;
  int unsigned idle_cycles;
  int unsigned cyc;

  function automatic int unsigned zend();
    return zend_reg > NFRAMES ? NFRAMES : zend_reg;
  endfunction

  function automatic bit in_zone(int unsigned f);
    return f >= zfirst && f < zend();
  endfunction

  function automatic bit block_fits(int unsigned f, int unsigned o);
    int unsigned n;
    n = 1 << o;
    if ((f & (n - 1)) != 0) return 0;
    return f >= zfirst && f + n <= zend();
  endfunction

  function automatic void unlink_frame(int unsigned f);
    int unsigned o;
    f = f & 16'hFFFF;
    o = fr_ord[f] % NORDERS;
    if (fr_pok[f]) begin
      fr_next[fr_prev[f]] = fr_next[f];
      fr_nok[fr_prev[f]] = fr_nok[f];
    end else begin
      lhead[o] = fr_next[f];
      lhead_ok[o] = fr_nok[f];
    end
    if (fr_nok[f]) begin
      fr_prev[fr_next[f]] = fr_prev[f];
      fr_pok[fr_next[f]] = fr_pok[f];
    end
    if (lcount[o] != 0) lcount[o]--;
    fr_mark[f] = 0;
    fr_pok[f] = 0;
    fr_nok[f] = 0;
  endfunction

  function automatic void push_free(int unsigned o, int unsigned f);
    f = f & 16'hFFFF;
    if (fr_mark[f]) unlink_frame(f);
    fr_mark[f] = 1;
    fr_ord[f] = 4'(o);
    fr_pok[f] = 0;
    fr_nok[f] = 0;
    if (lhead_ok[o]) begin
      fr_prev[lhead[o]] = 16'(f);
      fr_pok[lhead[o]] = 1;
      fr_next[f] = lhead[o];
      fr_nok[f] = 1;
    end
    lhead[o] = 16'(f);
    lhead_ok[o] = 1;
    lcount[o]++;
  endfunction

  function automatic bit is_head(int unsigned f, int unsigned o);
    return fr_mark[f & 16'hFFFF] && fr_ord[f & 16'hFFFF] == o;
  endfunction

  function automatic void coalesce(int unsigned f, int unsigned o);
    int unsigned b;
    while (o + 1 < NORDERS) begin
      b = f ^ (1 << o);
      if (!in_zone(b) || !block_fits(b, o) || !is_head(b, o)) break;
      unlink_frame(b);
      if (b < f) f = b;
      o++;
    end
    push_free(o, f);
  endfunction

  function automatic bit inside_free(int unsigned f, int unsigned o);
    int unsigned h;
    for (int unsigned i = o; i < NORDERS; i++) begin
      h = f & ~((1 << i) - 1);
      if (in_zone(h) && is_head(h, i)) return 1;
    end
    return 0;
  endfunction

  function automatic alloc_rsp_t serve(alloc_req_t r);
    alloc_rsp_t res;
    int unsigned k, o, f, s, e, rem, osz, oal, ord;
    bit found;
    longint unsigned sum;
    res = '0;
    res.status = ST_OK;
    if (r.op == OP_ALLOC) begin
      k = 0;
      found = 0;
      if (r.cnt == 0) res.status = ST_BADREQ;
      while (res.status == ST_OK && (1 << k) < r.cnt) begin
        k++;
        if (k >= NORDERS) res.status = ST_BADREQ;
      end
      if (res.status == ST_OK) begin
        for (o = k; o < NORDERS; o++) begin
          if (lhead_ok[o]) begin
            found = 1;
            break;
          end
        end
        if (!found) res.status = ST_NOMEM;
        else begin
          f = lhead[o];
          unlink_frame(f);
          while (o > k) begin
            o--;
            push_free(o, f + (1 << o));
          end
          fr_ord[f] = 4'(k);
          res.gframe = 16'(f);
          res.gpages = 11'(1 << k);
        end
      end
    end else if (r.op == OP_FREE) begin
      if (r.bord >= NORDERS) res.status = ST_BADREQ;
      else if (!block_fits(r.fr, r.bord)) res.status = ST_INVALID;
      else if (fr_mark[r.fr] || inside_free(r.fr, r.bord)) res.status = ST_DBLFREE;
      else coalesce(r.fr, r.bord);
    end else if (r.op == OP_ADD) begin
      s = r.fr;
      e = r.ef;
      if (s < e) begin
        if (s == 0) s = 1;
        if (s < zfirst) s = zfirst;
        if (e > zend()) e = zend();
        while (s < e) begin
          rem = e - s;
          osz = 0;
          oal = 0;
          while (osz + 1 < NORDERS && (1 << (osz + 1)) <= rem) osz++;
          while (oal + 1 < NORDERS && ((s >> oal) & 1) == 0) oal++;
          ord = osz < oal ? osz : oal;
          coalesce(s, ord);
          s += 1 << ord;
        end
      end
    end else begin
      res.status = ST_BADREQ;
    end
    sum = 0;
    for (int i = 0; i < NORDERS; i++) sum += longint'(lcount[i]) << i;
    res.apages = sum > AVAIL_PAGES_MAX ? AVAIL_PAGES_MAX : sum[16:0];
    return res;
  endfunction

  task automatic send(input alloc_req_t r, output alloc_rsp_t res);
    block_t b;
    res = serve(r);
    pending_reqs.push_back(r);
    expected_rsps.push_back(res);
    if (r.op == OP_ALLOC && res.status == ST_OK) begin
      b.fr = res.gframe;
      b.ord = 4'($clog2(res.gpages));
      live_blocks.push_back(b);
    end
  endtask

  function automatic alloc_req_t mk(logic [1:0] op, int unsigned cnt, int unsigned bord,
                                    int unsigned fr, int unsigned ef);
    alloc_req_t r;
    r.op = op;
    r.cnt = 16'(cnt);
    r.bord = 4'(bord);
    r.fr = 16'(fr);
    r.ef = 17'(ef);
    return r;
  endfunction

  task automatic random_item();
    alloc_req_t r;
    alloc_rsp_t res;
    block_t b;
    int unsigned sel, idx, s, span;
    sel = $urandom_range(0, 99);
    r = mk(OP_ALLOC, 0, 0, 0, 0);
    if (sel < 35) begin
      if ($urandom_range(0, 19) == 0) r.cnt = 16'($urandom());
      else if ($urandom_range(0, 9) == 0) r.cnt = 16'($urandom_range(1, 1024));
      else r.cnt = 16'($urandom_range(1, 64));
    end else if (sel < 70 && live_blocks.size() != 0) begin
      idx = $urandom_range(0, live_blocks.size() - 1);
      b = live_blocks[idx];
      live_blocks.delete(idx);
      freed_blocks.push_back(b);
      if (freed_blocks.size() > 32) void'(freed_blocks.pop_front());
      r = mk(OP_FREE, $urandom(), b.ord, b.fr, $urandom());
    end else if (sel < 75 && freed_blocks.size() != 0) begin
      b = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
      r = mk(OP_FREE, $urandom(), b.ord, b.fr, $urandom());
    end else if (sel < 87) begin
      span = zend() > zfirst ? zend() - zfirst : 0;
      s = zfirst + $urandom_range(0, span);
      if (s > 16'hFFFF) s = 16'hFFFF;
      r.op = OP_ADD;
      r.fr = 16'(s);
      r.ef = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(0, 17'h1FFFF))
                                         : 17'(s + $urandom_range(0, 2048));
      r.cnt = 16'($urandom());
    end else begin
      r = mk(2'($urandom_range(0, 3)), $urandom(), $urandom_range(0, 15), $urandom(),
             $urandom_range(0, 17'h1FFFF));
    end
    send(r, res);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= 17'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ZONE_FIRST) zfirst = val & 16'hFFFF;
    else zend_reg = val & 17'h1FFFF;
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic directed();
    alloc_rsp_t res;
    alloc_rsp_t big;
    alloc_rsp_t one;
    send(mk(OP_ALLOC, 1, 0, 0, 0), res);
    send(mk(OP_UNUSED, 16'hFFFF, 15, 16'hFFFF, 17'h1FFFF), res);
    send(mk(OP_ADD, 0, 0, 0, 64), res);
    send(mk(OP_ADD, 0, 0, 100, 100), res);
    send(mk(OP_ADD, 0, 0, 200, 150), res);
    send(mk(OP_ALLOC, 0, 0, 0, 0), res);
    send(mk(OP_ALLOC, 1025, 0, 0, 0), res);
    send(mk(OP_ALLOC, 16'hFFFF, 0, 0, 0), res);
    send(mk(OP_ALLOC, 1024, 0, 0, 0), res);
    send(mk(OP_ADD, 0, 0, 0, 17'h10000), res);
    send(mk(OP_ALLOC, 1024, 0, 0, 0), big);
    send(mk(OP_ALLOC, 1, 0, 0, 0), one);
    send(mk(OP_ALLOC, 3, 0, 0, 0), res);
    send(mk(OP_FREE, 0, 11, 0, 0), res);
    send(mk(OP_FREE, 0, 15, 16'hFFFF, 0), res);
    send(mk(OP_FREE, 0, 2, 3, 0), res);
    send(mk(OP_FREE, 0, 1, 16'hFFFF, 0), res);
    send(mk(OP_FREE, 0, 1, 16'hFFFE, 0), res);
    send(mk(OP_FREE, 0, 10, big.gframe, 0), res);
    send(mk(OP_FREE, 0, 10, big.gframe, 0), res);
    send(mk(OP_FREE, 0, 9, big.gframe + 512, 0), res);
    send(mk(OP_FREE, 0, 0, one.gframe, 0), res);
    send(mk(OP_ADD, 0, 0, 16'hFFFF, 17'h1FFFF), res);
    send(mk(OP_ALLOC, 512, 0, 0, 0), res);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        req_if.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs.pop_front();
        req_if.valid <= 1'b1;
        req_if.op <= nxt.op;
        req_if.page_count <= nxt.cnt;
        req_if.block_order <= nxt.bord;
        req_if.frame_number <= nxt.fr;
        req_if.end_frame <= nxt.ef;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= cyc[11] ? 0 : $urandom_range(0, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!cyc[10] && $urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 12);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected transfer status=%0d frame=%0d pages=%0d avail=%0d",
                   $time, rsp_if.status, rsp_if.granted_frame, rsp_if.granted_pages,
                   rsp_if.avail_pages);
          errors++;
        end else begin
          if ({rsp_if.status, rsp_if.granted_frame, rsp_if.granted_pages,
               rsp_if.avail_pages} !== expected_rsps[0]) begin
            $display("%0t: mismatch exp status=%0d frame=%0d pages=%0d avail=%0d",
                     $time, expected_rsps[0].status, expected_rsps[0].gframe,
                     expected_rsps[0].gpages, expected_rsps[0].apages);
            $display("%0t:          got status=%0d frame=%0d pages=%0d avail=%0d",
                     $time, rsp_if.status, rsp_if.granted_frame, rsp_if.granted_pages,
                     rsp_if.avail_pages);
            errors++;
          end
          void'(expected_rsps.pop_front());
          rsp_checked++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned zones[5][3];
    zones = '{'{0, 65536, 450}, '{4096, 20000, 250}, '{65535, 131071, 100},
              '{0, 0, 100}, '{1024, 65536, 200}};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.op = OP_ALLOC;
    req_if.page_count = '0;
    req_if.block_order = '0;
    req_if.frame_number = '0;
    req_if.end_frame = '0;
    rsp_if.ready = 1'b0;
    errors = 0;
    rsp_checked = 0;
    gap_left = 0;
    burst_left = 0;
    stall_left = 0;
    idle_cycles = 0;
    cyc = 0;
    zfirst = 0;
    zend_reg = 65536;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_ZONE_FIRST, zones[p][0]);
      write_reg(CFG_ZONE_END, zones[p][1]);
      if (p == 0) directed();
      for (int i = 0; i < zones[p][2]; i++) random_item();
      drain();
    end
    $display("checked %0d transfers over five zone settings, alloc/free/add and bad requests",
             rsp_checked);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
